// ===== design/tgr_pkg.sv =====
// Shared types and constants of the TGA run-length decoder.
package tgr_pkg;

    localparam int PIXEL_BITS         = 32;
    localparam int BYTE_BITS          = 8;
    localparam int RUN_BITS           = 8;
    localparam int BPP_BITS           = 3;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 25;
    localparam int COUNT_BITS_DEFAULT = 25;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [BPP_BITS-1:0]  BPP_RESET = 3'd3;
    localparam logic [BPP_BITS-1:0]  BPP_MIN   = 3'd1;
    localparam logic [BPP_BITS-1:0]  BPP_MAX   = 3'd4;
    localparam logic [BYTE_BITS-1:0] RAW_LIMIT = 8'd128;
    localparam logic [BYTE_BITS-1:0] RUN_BIAS  = 8'd127;
    localparam logic [CFG_DATA_BITS-1:0] TOTAL_RESET = 25'd1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_REG_BPP   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REG_TOTAL = 2'd1;

    // One decoded pixel to be written count times; count already limited to the image.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] px;
        logic [RUN_BITS-1:0]   count;
        logic                  over;
        logic                  done;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== design/tgr_front.sv =====
// Front part: packet parsing, pixel assembly and pixel counting.
module tgr_front #(
    parameter int COUNT_BITS = tgr_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic [tgr_pkg::BYTE_BITS-1:0]        i_stream_byte,
    input  logic                                 i_frame_start,
    input  logic [tgr_pkg::BPP_BITS-1:0]         i_bpp,
    input  logic [COUNT_BITS-1:0]                i_total,
    output logic                                 o_push,
    output tgr_pkg::t_cmd                        o_cmd
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_RAW    = 3'b010,
        PH_RUN    = 3'b100
    } t_phase;

    t_phase                          r_phase, n_phase, phase_c;
    logic [tgr_pkg::RUN_BITS-1:0]    r_remaining, n_remaining;
    logic [1:0]                      r_pos, n_pos;
    logic [tgr_pkg::PIXEL_BITS-1:0]  r_asm, n_asm, asm_new;
    logic [COUNT_BITS-1:0]           r_written, n_written, written_c, room, written_after;
    logic                            r_halted, n_halted, halted_c;
    logic [tgr_pkg::BPP_BITS-1:0]    bpp_eff;
    logic [tgr_pkg::RUN_BITS-1:0]    want, fit;
    logic                            fits;

    always_comb begin
        priority if (i_bpp == '0) begin
            bpp_eff = tgr_pkg::BPP_MIN;
        end else if (i_bpp > tgr_pkg::BPP_MAX) begin
            bpp_eff = tgr_pkg::BPP_MAX;
        end else begin
            bpp_eff = i_bpp;
        end
    end

    // frame_start clears the counters before the byte is taken
    assign phase_c   = i_frame_start ? PH_HEADER : r_phase;
    assign written_c = i_frame_start ? '0 : r_written;
    assign halted_c  = i_frame_start ? 1'b0 : r_halted;

    assign asm_new = r_asm | (tgr_pkg::PIXEL_BITS'(i_stream_byte) << {r_pos, 3'b000});
    assign want    = (phase_c == PH_RAW) ? tgr_pkg::RUN_BITS'(1) : r_remaining;
    assign room    = (i_total > written_c) ? (i_total - written_c) : '0;
    assign fits    = COUNT_BITS'(want) <= room;
    assign fit     = fits ? want : tgr_pkg::RUN_BITS'(room);
    assign written_after = written_c + COUNT_BITS'(fit);

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_pos       = r_pos;
        n_asm       = r_asm;
        n_written   = r_written;
        n_halted    = r_halted;
        o_push      = 1'b0;
        o_cmd.px    = asm_new;
        o_cmd.count = fit;
        o_cmd.over  = !fits;
        o_cmd.done  = (written_after == i_total) && (fit != '0);
        if (i_accept) begin
            n_phase   = phase_c;
            n_written = written_c;
            n_halted  = halted_c;
            if (!halted_c) begin
                if (phase_c == PH_HEADER) begin
                    if (i_stream_byte < tgr_pkg::RAW_LIMIT) begin
                        n_phase     = PH_RAW;
                        n_remaining = i_stream_byte + tgr_pkg::RUN_BITS'(1);
                    end else begin
                        n_phase     = PH_RUN;
                        n_remaining = i_stream_byte - tgr_pkg::RUN_BIAS;
                    end
                    n_pos = '0;
                    n_asm = '0;
                end else if (({1'b0, r_pos} + 3'd1) < bpp_eff) begin
                    n_pos = r_pos + 2'd1;
                    n_asm = asm_new;
                end else begin
                    // pixel complete: hand it to the back part
                    o_push    = 1'b1;
                    n_pos     = '0;
                    n_asm     = '0;
                    n_written = written_after;
                    n_halted  = !fits;
                    if (phase_c == PH_RAW) begin
                        n_remaining = r_remaining - tgr_pkg::RUN_BITS'(1);
                        if (r_remaining == tgr_pkg::RUN_BITS'(1)) begin
                            n_phase = PH_HEADER;
                        end
                    end else begin
                        n_remaining = '0;
                        n_phase     = PH_HEADER;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_remaining <= '0;
            r_pos       <= '0;
            r_written   <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_pos       <= n_pos;
            r_written   <= n_written;
            r_halted    <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asm <= '0;
        end else begin
            r_asm <= n_asm;
        end
    end

endmodule

// ===== design/tgr_queue.sv =====
// Short command queue between the front and back parts.
module tgr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tgr_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output tgr_pkg::t_cmd       o_cmd,
    output tgr_pkg::t_q_status  o_status
);

    localparam int DEPTH   = tgr_pkg::QUEUE_DEPTH;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(DEPTH);

    tgr_pkg::t_cmd       r_entry [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [COUNT_W-1:0]  r_count;
    logic                do_push, do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_cmd   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + COUNT_W'(do_push) - COUNT_W'(do_pop);
        end
    end

endmodule

// ===== design/tgr_back.sv =====
// Back part: expands commands into results of up to two pixels each.
module tgr_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tgr_pkg::t_cmd                        i_cmd,
    input  logic                                 i_cmd_avail,
    output logic                                 o_pop,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [tgr_pkg::PIXEL_BITS-1:0]       o_pixel_first,
    output logic [tgr_pkg::PIXEL_BITS-1:0]       o_pixel_second,
    output logic [1:0]                           o_pixel_valid,
    output logic                                 o_image_done,
    output logic                                 o_overrun,
    output logic                                 o_last
);

    logic                          r_busy;
    tgr_pkg::t_cmd                 r_cmd;
    logic [tgr_pkg::RUN_BITS-1:0]  r_left;
    logic                          out_free, emit, emit_last;
    logic [1:0]                    emit_n;

    assign out_free  = !o_valid || !i_stall;
    assign emit      = r_busy && out_free;
    assign emit_last = r_left <= tgr_pkg::RUN_BITS'(2);
    assign emit_n    = (r_left >= tgr_pkg::RUN_BITS'(2)) ? 2'd2 : r_left[1:0];
    // take the next command as the current one finishes
    assign o_pop     = i_cmd_avail && (!r_busy || (emit && emit_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && emit_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_left <= i_cmd.count;
        end else if (emit) begin
            r_left <= r_left - tgr_pkg::RUN_BITS'(emit_n);
        end
        if (emit) begin
            o_pixel_first  <= (emit_n != 2'd0) ? r_cmd.px : '0;
            o_pixel_second <= (emit_n == 2'd2) ? r_cmd.px : '0;
            o_pixel_valid  <= emit_n;
            o_image_done   <= emit_last && r_cmd.done;
            o_overrun      <= emit_last && r_cmd.over;
            o_last         <= emit_last;
        end
    end

endmodule

// ===== design/tga_rle_decoder.sv =====
// Top level of the TGA run-length decoder: configuration registers and part wiring.
// Takes one packet byte per cycle while the two-entry command queue has room; a header
// byte or a byte that does not finish a pixel gives no result. The byte that finishes
// a pixel queues one command, and the back part drains each command at one result
// per cycle while i_stall is low, up to two pixels per result: ceil(n/2) results for n
// pixels, one for a raw pixel or an overrun with no pixel left. Long runs therefore hold
// o_stall high once the queue is full. Registers are taken on any cycle (o_cfg_ready is
// always high) and should be written only while the decoder is idle; bytes_per_pixel
// of 0 acts as 1 and above 4 acts as 4. After an overrun bytes are dropped until one
// arrives with frame_start set.
module tga_rle_decoder #(
    parameter int COUNT_BITS = tgr_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [tgr_pkg::BYTE_BITS-1:0]        i_stream_byte,
    input  logic                                 i_frame_start,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [tgr_pkg::PIXEL_BITS-1:0]       o_pixel_first,
    output logic [tgr_pkg::PIXEL_BITS-1:0]       o_pixel_second,
    output logic [1:0]                           o_pixel_valid,
    output logic                                 o_image_done,
    output logic                                 o_overrun,
    output logic                                 o_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tgr_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [tgr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [tgr_pkg::BPP_BITS-1:0]  r_bpp;
    logic [COUNT_BITS-1:0]         r_total;
    logic                          in_accept, push, pop;
    tgr_pkg::t_cmd                 push_cmd, head_cmd;
    tgr_pkg::t_q_status            q_status;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_status.full;
    assign in_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp   <= tgr_pkg::BPP_RESET;
            r_total <= COUNT_BITS'(tgr_pkg::TOTAL_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == tgr_pkg::CFG_REG_BPP) begin
                r_bpp <= i_cfg_data[tgr_pkg::BPP_BITS-1:0];
            end else if (i_cfg_index == tgr_pkg::CFG_REG_TOTAL) begin
                r_total <= COUNT_BITS'(i_cfg_data);
            end
        end
    end

    tgr_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_stream_byte (i_stream_byte),
        .i_frame_start (i_frame_start),
        .i_bpp         (r_bpp),
        .i_total       (r_total),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    tgr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    tgr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_cmd_avail    (!q_status.empty),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_pixel_first  (o_pixel_first),
        .o_pixel_second (o_pixel_second),
        .o_pixel_valid  (o_pixel_valid),
        .o_image_done   (o_image_done),
        .o_overrun      (o_overrun),
        .o_last         (o_last)
    );

    a_empty_is_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_valid == 2'd0) |-> (o_overrun && o_last))
        else $error("result without pixels that is not a final overrun");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_image_done || o_overrun)) |-> o_last)
        else $error("image_done or overrun on a result that is not last");

    a_inner_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_pixel_valid == 2'd2))
        else $error("non-final result carries fewer than two pixels");

    a_stall_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.full && !pop) |=> !q_status.empty)
        else $error("full command queue lost its entries");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the TGA run-length decoder: directed table, random packet streams.
`timescale 1ns / 1ps

module tb_top;

    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 12;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASE_ITEMS   = 16;
    localparam longint      TIMEOUT_NS    = 6_000_000;
    localparam logic [24:0] TOTAL_MAX     = 25'd16777216;
    localparam logic [24:0] DATA_ONES     = 25'h1FFFFFF;

    // Indexes past the register list; the block must ignore writes to them.
    localparam logic [tgr_pkg::CFG_INDEX_BITS-1:0] CFG_REG_SPARE_LO = 2'd2;
    localparam logic [tgr_pkg::CFG_INDEX_BITS-1:0] CFG_REG_SPARE_HI = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_RAW    = 3'b010,
        PH_RUN    = 3'b100
    } t_pkt_phase;
    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [tgr_pkg::PIXEL_BITS-1:0] first_px;
        logic [tgr_pkg::PIXEL_BITS-1:0] second_px;
        logic [1:0]                     count;
        logic                           done;
        logic                           over;
        logic                           last;
    } t_px_result;

    typedef struct {
        t_row_kind                          kind;
        logic [tgr_pkg::BYTE_BITS-1:0]      b;
        logic                               fs;
        logic [tgr_pkg::CFG_INDEX_BITS-1:0] idx;
        logic [tgr_pkg::CFG_DATA_BITS-1:0]  data;
        bit                                 typed;
        t_px_result                         res;
    } t_stim_row;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_valid       = 1'b0;
    logic [tgr_pkg::BYTE_BITS-1:0]      i_stream_byte = '0;
    logic                               i_frame_start = 1'b0;
    logic                               i_stall       = 1'b0;
    logic                               i_cfg_valid   = 1'b0;
    logic [tgr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index   = '0;
    logic [tgr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data    = '0;
    logic                               o_stall;
    logic                               o_valid;
    logic [tgr_pkg::PIXEL_BITS-1:0]     o_pixel_first;
    logic [tgr_pkg::PIXEL_BITS-1:0]     o_pixel_second;
    logic [1:0]                         o_pixel_valid;
    logic                               o_image_done;
    logic                               o_overrun;
    logic                               o_last;
    logic                               o_cfg_ready;

    tga_rle_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_stream_byte  (i_stream_byte),
        .i_frame_start  (i_frame_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_first  (o_pixel_first),
        .o_pixel_second (o_pixel_second),
        .o_pixel_valid  (o_pixel_valid),
        .o_image_done   (o_image_done),
        .o_overrun      (o_overrun),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Decoder copy: registers and packet state.
    logic [tgr_pkg::BPP_BITS-1:0]      bpp_reg    = tgr_pkg::BPP_RESET;
    logic [tgr_pkg::CFG_DATA_BITS-1:0] total_reg  = tgr_pkg::TOTAL_RESET;
    t_pkt_phase                        pkt_phase  = PH_HEADER;
    logic [tgr_pkg::RUN_BITS-1:0]      pkt_left   = '0;
    logic [1:0]                        byte_pos   = '0;
    logic [tgr_pkg::PIXEL_BITS-1:0]    px_build   = '0;
    logic [24:0]                       written_px = '0;
    bit                                halted     = 1'b0;

    t_px_result  pixel_results_due[$];
    t_stim_row   stim_rows[$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned send_pct       = 0;
    int unsigned recv_pct       = 0;
    int unsigned hold_req       = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;

    function automatic int unsigned eff_bpp(input logic [tgr_pkg::BPP_BITS-1:0] raw);
        if (raw < tgr_pkg::BPP_MIN) return 32'(tgr_pkg::BPP_MIN);
        if (raw > tgr_pkg::BPP_MAX) return 32'(tgr_pkg::BPP_MAX);
        return 32'(raw);
    endfunction

    function automatic void clear_packet_state();
        pkt_phase  = PH_HEADER;
        pkt_left   = '0;
        byte_pos   = '0;
        px_build   = '0;
        written_px = '0;
        halted     = 1'b0;
    endfunction

    // Queue n copies of px, two per result, cut off where the image is full.
    function automatic void emit_pixels(input logic [tgr_pkg::PIXEL_BITS-1:0] px,
                                        input int unsigned n);
        int unsigned room;
        int unsigned fit;
        int unsigned v;
        int unsigned i;
        bit          over;
        t_px_result  r;
        room = (total_reg > written_px) ? int'(total_reg - written_px) : 0;
        fit  = (n <= room) ? n : room;
        over = fit < n;
        for (i = 0; i < fit; i += 2) begin
            v           = (fit - i >= 2) ? 2 : 1;
            written_px  = written_px + 25'(v);
            r.first_px  = px;
            r.second_px = (v == 2) ? px : '0;
            r.count     = 2'(v);
            r.done      = (written_px == total_reg);
            r.last      = (i + 2 >= fit);
            r.over      = over && r.last;
            pixel_results_due.push_back(r);
        end
        if (fit == 0) begin
            r      = '0;
            r.over = 1'b1;
            r.last = 1'b1;
            pixel_results_due.push_back(r);
        end
        if (over) halted = 1'b1;
    endfunction

    function automatic void decode_byte(input logic [tgr_pkg::BYTE_BITS-1:0] b,
                                        input logic fs);
        int unsigned                    width;
        logic [tgr_pkg::PIXEL_BITS-1:0] px;
        width = eff_bpp(bpp_reg);
        if (fs) clear_packet_state();
        if (halted) return;
        if (pkt_phase == PH_HEADER) begin
            if (b < tgr_pkg::RAW_LIMIT) begin
                pkt_phase = PH_RAW;
                pkt_left  = b + 8'd1;
            end else begin
                pkt_phase = PH_RUN;
                pkt_left  = b - tgr_pkg::RUN_BIAS;
            end
            byte_pos = '0;
            px_build = '0;
            return;
        end
        px_build = px_build | (tgr_pkg::PIXEL_BITS'(b) << (8 * byte_pos));
        if (byte_pos + 1 < width) begin
            byte_pos = byte_pos + 2'd1;
            return;
        end
        px       = px_build;
        byte_pos = '0;
        px_build = '0;
        if (pkt_phase == PH_RAW) begin
            emit_pixels(px, 1);
            pkt_left = pkt_left - 8'd1;
            if (pkt_left == 0) pkt_phase = PH_HEADER;
        end else begin
            emit_pixels(px, 32'(pkt_left));
            pkt_left  = '0;
            pkt_phase = PH_HEADER;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_px_result seen;
        t_px_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = {o_pixel_first, o_pixel_second, o_pixel_valid,
                    o_image_done, o_overrun, o_last};
            if (pixel_results_due.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pixel_results_due.pop_front();
                check_field("pixel_first", seen.first_px, want.first_px);
                check_field("pixel_second", seen.second_px, want.second_px);
                check_field("pixel_valid", 32'(seen.count), 32'(want.count));
                check_field("image_done", 32'(seen.done), 32'(want.done));
                check_field("overrun", 32'(seen.over), 32'(want.over));
                check_field("last", 32'(seen.last), 32'(want.last));
            end
        end
    end

    // Receiver: random stall, or a long hold when the driver asks for one.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_served != hold_req) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_pct);
            end
        end
    end

    task automatic send_byte(input logic [tgr_pkg::BYTE_BITS-1:0] b, input logic fs,
                             input bit typed, input t_px_result typed_res);
        int unsigned depth;
        @(negedge i_clk);
        while ($urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        depth = pixel_results_due.size();
        decode_byte(b, fs);
        items_sent++;
        if (typed) begin
            while (pixel_results_due.size() > depth) void'(pixel_results_due.pop_back());
            pixel_results_due.push_back(typed_res);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= b;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [tgr_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [tgr_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tgr_pkg::CFG_REG_BPP:   bpp_reg = data[tgr_pkg::BPP_BITS-1:0];
            tgr_pkg::CFG_REG_TOTAL: total_reg = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, drain every result, then let a header or partial pixel settle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pixel_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_byte(input logic [7:0] b, input logic fs);
        stim_rows.push_back('{ROW_BYTE, b, fs, '0, '0, 1'b0, '0});
    endfunction

    function automatic void add_check(input logic [7:0] b, input logic fs,
                                      input t_px_result res);
        stim_rows.push_back('{ROW_BYTE, b, fs, '0, '0, 1'b1, res});
    endfunction

    function automatic void add_cfg(input logic [tgr_pkg::CFG_INDEX_BITS-1:0] idx,
                                    input logic [tgr_pkg::CFG_DATA_BITS-1:0] data);
        stim_rows.push_back('{ROW_CFG, '0, 1'b0, idx, data, 1'b0, '0});
    endfunction

    task automatic run_phase(input logic [tgr_pkg::BPP_BITS-1:0] bpp,
                             input logic [24:0] total,
                             input int unsigned snd, input int unsigned rcv,
                             input bit pressure);
        int unsigned goal;
        int unsigned target;
        int unsigned left;
        int unsigned n;
        int unsigned width;
        int unsigned roll;
        bit          first;
        bit          is_run;
        wait_idle();
        write_cfg(tgr_pkg::CFG_REG_BPP, tgr_pkg::CFG_DATA_BITS'(bpp));
        write_cfg(tgr_pkg::CFG_REG_TOTAL, total);
        send_pct = snd;
        recv_pct = rcv;
        width    = eff_bpp(bpp);
        if (pressure) hold_req++;
        // finish any pixel left half-built under the old width
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
        goal = items_sent + (pressure ? 2 * PHASE_ITEMS : PHASE_ITEMS);
        while (items_sent < goal) begin
            roll = $urandom_range(99);
            if (pressure) target = $urandom_range(400, 150);
            else if (total == 0 || total > 64) target = $urandom_range(40, 1);
            else if (roll < 70) target = total;
            else target = total + $urandom_range(6, 1);
            if (roll >= 85 && !pressure) begin
                repeat ($urandom_range(4, 1))
                    send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0), 1'b0, '0);
            end else begin
                left  = target;
                first = 1'b1;
                while (left > 0 && items_sent < goal) begin
                    if (pressure || $urandom_range(9) == 0) n = $urandom_range(128, 1);
                    else n = $urandom_range(8, 1);
                    is_run = pressure || $urandom_range(1);
                    if (!is_run && n > 24) n = 24;
                    if (n > left) n = left;
                    send_byte(8'(is_run ? n + tgr_pkg::RUN_BIAS : n - 1), first, 1'b0, '0);
                    first = 1'b0;
                    repeat (is_run ? width : n * width)
                        send_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
                    left -= n;
                end
            end
        end
        // start a run with one byte of its pixel; unless pixels are one byte, it stays open for the next width
        if ($urandom_range(1)) begin
            send_byte(8'($urandom_range(255, 128)), 1'b1, 1'b0, '0);
            send_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
        end
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        clear_packet_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: three bytes per pixel, one-pixel image.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_check(8'hAA, 1'b0, t_px_result'{32'h00AA00FF, 32'h0, 2'd1, 1'b1, 1'b0, 1'b1});
        // image already full: the run overruns with no pixel left
        add_byte(8'h80, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_check(8'h03, 1'b0, t_px_result'{32'h0, 32'h0, 2'd0, 1'b0, 1'b1, 1'b1});
        // halted: dropped
        add_byte(8'h55, 1'b0);
        // longest run and longest raw packet, image of 2^24 pixels
        add_cfg(tgr_pkg::CFG_REG_BPP, tgr_pkg::CFG_DATA_BITS'(tgr_pkg::BPP_MIN));
        add_cfg(tgr_pkg::CFG_REG_TOTAL, TOTAL_MAX);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h80, 1'b0);
        add_cfg(CFG_REG_SPARE_LO, DATA_ONES);
        add_cfg(CFG_REG_SPARE_HI, DATA_ONES);
        // zero width acts as one byte, empty image overruns at once
        add_cfg(tgr_pkg::CFG_REG_BPP, '0);
        add_cfg(tgr_pkg::CFG_REG_TOTAL, '0);
        add_byte(8'h81, 1'b1);
        add_check(8'h12, 1'b0, t_px_result'{32'h0, 32'h0, 2'd0, 1'b0, 1'b1, 1'b1});
        // oversized width acts as four bytes; the second run only partly fits
        add_cfg(tgr_pkg::CFG_REG_BPP, tgr_pkg::CFG_DATA_BITS'(3'd7));
        add_cfg(tgr_pkg::CFG_REG_TOTAL, 25'd5);
        add_byte(8'h83, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hFE, 1'b0);
        add_byte(8'h81, 1'b0);
        add_byte(8'hDE, 1'b0);
        add_byte(8'hAD, 1'b0);
        add_byte(8'hBE, 1'b0);
        add_check(8'hEF, 1'b0, t_px_result'{32'hEFBEADDE, 32'h0, 2'd1, 1'b1, 1'b1, 1'b1});

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_cfg(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_byte(stim_rows[i].b, stim_rows[i].fs, stim_rows[i].typed,
                          stim_rows[i].res);
            end
        end

        run_phase(tgr_pkg::BPP_MAX, TOTAL_MAX, 0, 0, 1'b1);
        run_phase(3'd3, 25'($urandom_range(40, 1)), 70, 0, 1'b0);
        run_phase(tgr_pkg::BPP_MIN, 25'($urandom_range(40, 1)), 0, 70, 1'b0);
        run_phase(3'd2, 25'($urandom_range(40, 1)), 20, 20, 1'b0);
        run_phase(3'd0, 25'($urandom_range(40, 1)), 0, 0, 1'b0);
        run_phase(3'd7, 25'($urandom_range(40, 1)), 70, 0, 1'b0);
        run_phase(tgr_pkg::BPP_MAX, '0, 0, 70, 1'b0);
        run_phase(3'd5, 25'($urandom_range(40, 1)), 20, 20, 1'b0);
        run_phase(3'($urandom_range(7)), DATA_ONES, 0, 0, 1'b0);
        run_phase(3'($urandom_range(7)), 25'($urandom_range(64, 1)), 20, 20, 1'b0);
        run_phase(3'($urandom_range(7)), 25'($urandom_range(40, 1)), 0, 70, 1'b0);
        run_phase(3'd3, 25'($urandom_range(40, 1)), 70, 0, 1'b0);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
